// ===== src/ptc_pkg.sv =====
// Shared types, opcodes and constants for the pressure and temperature compensation block.
package ptc_pkg;

    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 64;

    localparam logic [CfgIdxW-1:0] REG_TEMP_COEF = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_PRES_LOW  = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_PRES_HIGH = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_PRES_NINE = 2'd3;

    localparam int NumRegs = 4;
    localparam int RegIdxW = 3;

    // Accumulator constants of the compensation polynomials.
    localparam logic [63:0] FINE_OFFSET = 64'd128000;
    localparam logic [63:0] PRES_BASE   = 64'd1048576;
    localparam logic [63:0] PRES_SCALE  = 64'd3125;
    localparam logic [63:0] ROUND_HALF  = 64'd128;

    // Number of cycles of the bit-serial divider, one quotient bit each.
    localparam int DivCycles = 64;

    typedef struct packed {
        logic        action;
        logic [19:0] raw_sample;
    } t_in_item;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] temperature;
        logic        [31:0] pressure;
        logic               divide_by_zero;
    } t_out_item;

    // Operand selectors for the shared multiplier.
    typedef enum logic [4:0] {
        OP_T_A,       // ((raw>>3)-(t1<<1))*t2
        OP_T_DD,      // d*d
        OP_T_B,       // (dd>>12)*t3
        OP_T_FIN,     // fine = a+b, temp out
        OP_P_AA,      // a*a
        OP_P_B6,      // aa*p6
        OP_P_A5,      // a*p5
        OP_P_A3,      // aa*p3
        OP_P_A2,      // a*p2
        OP_P_X1,      // ((1<<47)+a)*p1
        OP_P_NUM,     // numerator*3125
        OP_P_Q13,     // (p>>13)*(p>>13)
        OP_P_Q9,      // p9*that
        OP_P_Q8,      // p8*p
        OP_P_FIN      // final sum
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul_start;
        t_op  op;
        logic div_start;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mul_done;
        logic div_zero;
        logic div_done;
    } t_sts;

endpackage

// ===== src/pressure_temperature_compensation.sv =====
// Top level of the barometric pressure and temperature compensation block.
// Compensates raw 20-bit sensor readings one at a time. A temperature item makes
// three passes of the shared 64x64 multiplier, with start and hand-off, plus setup
// and output; a pressure item makes ten multiplier passes and a run of the
// bit-serial divider, and stops before the divider when the divisor is zero.
// A new item is taken only after the previous result has been transferred.
// Configuration writes land at once.
module pressure_temperature_compensation
    import ptc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_item            i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_item           o_out_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    ptc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_in_data.action),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    ptc_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_in_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_result   (o_out_data)
    );

endmodule

// ===== src/ptc_mul.sv =====
// Iterative 64x64 wrapping multiplier, sixteen bits of the multiplier per cycle.
module ptc_mul
    import ptc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_prod
);

    logic [63:0] r_acc, n_acc;
    logic [63:0] r_a, r_b;
    logic [1:0]  r_cnt;
    logic        r_busy, r_done;
    logic [79:0] w_part;

    // One 64x16 partial product per cycle; the result wraps at 64 bits.
    assign w_part = r_a * {64'd0, r_b[15:0]};
    assign n_acc  = r_acc + w_part[63:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_a   <= {r_a[47:0], 16'd0};
            r_b   <= {16'd0, r_b[63:16]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== src/ptc_div.sv =====
// Signed 64-bit restoring divider, one quotient bit per cycle, truncating toward zero.
module ptc_div
    import ptc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quot
);

    logic [63:0] r_rem, r_quo, r_den;
    logic        r_neg, r_busy, r_done;
    logic [5:0]  r_cnt;
    logic [64:0] w_shift, w_diff;
    logic [63:0] w_an, w_ad;

    assign w_an    = i_num[63] ? (64'd0 - i_num) : i_num;
    assign w_ad    = i_den[63] ? (64'd0 - i_den) : i_den;
    assign w_shift = {r_rem, r_quo[63]};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(DivCycles - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift in one dividend bit and subtract the divisor where it fits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= w_an;
            r_den <= w_ad;
            r_neg <= i_num[63] ^ i_den[63];
        end else if (r_busy) begin
            if (!w_diff[64]) begin
                r_rem <= w_diff[63:0];
                r_quo <= {r_quo[62:0], 1'b1};
            end else begin
                r_rem <= w_shift[63:0];
                r_quo <= {r_quo[62:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (64'd0 - r_quo) : r_quo;

endmodule

// ===== src/ptc_datapath.sv =====
// Datapath: coefficient registers, kept fine temperature, working registers and arithmetic units.
module ptc_datapath
    import ptc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  t_in_item            i_item,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    output t_out_item           o_result
);

    logic [47:0] r_tc;
    logic [63:0] r_pl, r_ph;
    logic [15:0] r_p9;
    logic [31:0] r_fine;
    logic        r_action;
    logic [19:0] r_raw;
    // Working registers: x and y hold intermediate terms, aa holds a*a.
    logic [63:0] r_x, r_y, r_aa, r_a;
    logic [31:0] r_temp_out, r_pres_out;
    logic        r_dz;

    logic [63:0] w_ma, w_mb, w_prod, w_quot;
    logic        w_mdone, w_ddone;
    logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] w_raw, w_tf, w_num;

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] asr(input logic [63:0] v, input logic [5:0] s);
        return $unsigned($signed(v) >>> s);
    endfunction

    function automatic logic [63:0] w_tf5(input logic [31:0] f);
        return ({{32{f[31]}}, f} * 64'd5) + ROUND_HALF;
    endfunction

    assign t1 = {48'd0, r_tc[15:0]};
    assign t2 = sx16(r_tc[31:16]);
    assign t3 = sx16(r_tc[47:32]);
    assign p1 = {48'd0, r_pl[15:0]};
    assign p2 = sx16(r_pl[31:16]);
    assign p3 = sx16(r_pl[47:32]);
    assign p4 = sx16(r_pl[63:48]);
    assign p5 = sx16(r_ph[15:0]);
    assign p6 = sx16(r_ph[31:16]);
    assign p7 = sx16(r_ph[47:32]);
    assign p8 = sx16(r_ph[63:48]);
    assign p9 = sx16(r_p9);
    assign w_raw = {44'd0, r_raw};
    assign w_tf  = {{32{r_fine[31]}}, r_fine};
    assign w_num = ((PRES_BASE - w_raw) << 31) - r_y;

    // Multiplier operand selection for each step of the program.
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (i_cmd.op)
            OP_T_A: begin
                w_ma = (w_raw >> 3) - (t1 << 1);
                w_mb = t2;
            end
            OP_T_DD: begin
                w_ma = (w_raw >> 4) - t1;
                w_mb = (w_raw >> 4) - t1;
            end
            OP_T_B: begin
                w_ma = asr(r_y, 6'd12);
                w_mb = t3;
            end
            OP_P_AA: begin
                w_ma = r_a;
                w_mb = r_a;
            end
            OP_P_B6: begin
                w_ma = r_aa;
                w_mb = p6;
            end
            OP_P_A5: begin
                w_ma = r_a;
                w_mb = p5;
            end
            OP_P_A3: begin
                w_ma = r_aa;
                w_mb = p3;
            end
            OP_P_A2: begin
                w_ma = r_a;
                w_mb = p2;
            end
            OP_P_X1: begin
                w_ma = (64'd1 << 47) + r_x;
                w_mb = p1;
            end
            OP_P_NUM: begin
                w_ma = w_num;
                w_mb = PRES_SCALE;
            end
            OP_P_Q13: begin
                w_ma = asr(r_y, 6'd13);
                w_mb = asr(r_y, 6'd13);
            end
            OP_P_Q9: begin
                w_ma = p9;
                w_mb = r_x;
            end
            OP_P_Q8: begin
                w_ma = p8;
                w_mb = r_y;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    ptc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mdone),
        .o_prod  (w_prod)
    );

    ptc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_y),
        .i_den   (r_x),
        .o_done  (w_ddone),
        .o_quot  (w_quot)
    );

    // Configuration registers and the kept fine temperature.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc   <= '0;
            r_pl   <= '0;
            r_ph   <= '0;
            r_p9   <= '0;
            r_fine <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TEMP_COEF: r_tc <= i_cfg_data[47:0];
                    REG_PRES_LOW:  r_pl <= i_cfg_data;
                    REG_PRES_HIGH: r_ph <= i_cfg_data;
                    REG_PRES_NINE: r_p9 <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_cmd.finish && i_cmd.op == OP_T_FIN) begin
                r_fine <= r_x[31:0] + r_y[31:0];
            end
        end
    end

    // Working registers take each product as the program asks.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action   <= i_item.action;
            r_raw      <= i_item.raw_sample;
            r_a        <= w_tf - FINE_OFFSET;
            r_dz       <= 1'b0;
            r_temp_out <= '0;
            r_pres_out <= '0;
        end
        if (w_mdone) begin
            case (i_cmd.op)
                OP_T_A:   r_x  <= asr(w_prod, 6'd11);
                OP_T_DD:  r_y  <= w_prod;
                OP_T_B:   r_y  <= asr(w_prod, 6'd14);
                OP_P_AA:  r_aa <= w_prod;
                OP_P_B6:  r_y  <= w_prod + (p4 << 35);
                OP_P_A5:  r_y  <= r_y + (w_prod << 17);
                OP_P_A3:  r_x  <= asr(w_prod, 6'd8);
                OP_P_A2:  r_x  <= r_x + (w_prod << 12);
                OP_P_X1: begin
                    r_x  <= asr(w_prod, 6'd33);
                    r_dz <= (asr(w_prod, 6'd33) == 64'd0);
                end
                OP_P_NUM: r_y  <= w_prod;
                OP_P_Q13: r_x  <= w_prod;
                OP_P_Q9:  r_x  <= asr(w_prod, 6'd25);
                OP_P_Q8:  r_x  <= r_x + asr(w_prod, 6'd19);
                default: ;
            endcase
        end
        if (w_ddone) begin
            r_y <= w_quot;
        end
        if (i_cmd.finish) begin
            if (i_cmd.op == OP_T_FIN) begin
                r_temp_out <= 32'(asr(64'(w_tf5(r_x[31:0] + r_y[31:0])), 6'd8));
            end else if (i_cmd.op == OP_P_FIN) begin
                // A zero divisor leaves the pressure at zero.
                if (!r_dz) begin
                    r_pres_out <= 32'(asr(r_y + r_x, 6'd8) + (p7 << 4));
                end
            end
        end
    end

    assign o_sts.mul_done = w_mdone;
    assign o_sts.div_done = w_ddone;
    assign o_sts.div_zero = (r_x == 64'd0);

    assign o_result.kind           = r_action;
    assign o_result.temperature    = r_temp_out;
    assign o_result.pressure       = r_pres_out;
    assign o_result.divide_by_zero = r_dz;

endmodule

// ===== src/ptc_ctrl.sv =====
// Controller: steps the datapath through the temperature or pressure program.
module ptc_ctrl
    import ptc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_action,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic   r_go, n_go;
    logic   r_pres, n_pres;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_T_A;
            r_go    <= 1'b0;
            r_pres  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_go    <= n_go;
            r_pres  <= n_pres;
        end
    end

    // Sequence of multiplier steps; the divide sits between the numerator and the tail.
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_go        = 1'b0;
        n_pres      = r_pres;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        o_cmd.op    = r_op;
        o_cmd.mul_start = r_go;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_pres     = i_action;
                    n_op       = i_action ? OP_P_AA : OP_T_A;
                    n_go       = 1'b1;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                if (i_sts.mul_done) begin
                    n_go = 1'b1;
                    case (r_op)
                        OP_T_A:   n_op = OP_T_DD;
                        OP_T_DD:  n_op = OP_T_B;
                        OP_T_B: begin
                            n_op = OP_T_FIN;
                            n_go = 1'b0;
                            n_state = ST_OUT;
                        end
                        OP_P_AA:  n_op = OP_P_B6;
                        OP_P_B6:  n_op = OP_P_A5;
                        OP_P_A5:  n_op = OP_P_A3;
                        OP_P_A3:  n_op = OP_P_A2;
                        OP_P_A2:  n_op = OP_P_X1;
                        OP_P_X1:  n_op = OP_P_NUM;
                        OP_P_NUM: begin
                            n_go = 1'b0;
                            n_state = ST_DIV;
                        end
                        OP_P_Q13: n_op = OP_P_Q9;
                        OP_P_Q9:  n_op = OP_P_Q8;
                        OP_P_Q8: begin
                            n_op = OP_P_FIN;
                            n_go = 1'b0;
                            n_state = ST_OUT;
                        end
                        default: begin
                            n_go = 1'b0;
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                // Divisor zero skips the divide and the tail.
                if (r_op == OP_P_NUM) begin
                    if (i_sts.div_zero) begin
                        n_op    = OP_P_FIN;
                        n_state = ST_OUT;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_op = OP_P_Q13;
                    end
                end else if (i_sts.div_done) begin
                    n_go    = 1'b1;
                    n_state = ST_MUL;
                end
            end
            ST_OUT: begin
                // Result registers load in the first cycle, then the transfer is offered.
                if (!r_go) begin
                    o_cmd.finish = 1'b1;
                    n_go         = 1'b1;
                    o_cmd.mul_start = 1'b0;
                end else begin
                    o_cmd.mul_start = 1'b0;
                    o_out_valid = 1'b1;
                    n_go        = 1'b1;
                    if (i_out_ready) begin
                        n_go    = 1'b0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // The input is only taken while nothing is in flight.
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == ST_IDLE)) else $error("ready outside idle");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready and valid together");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid) else $error("result dropped");
    a_div_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> r_pres) else $error("divide on temperature item");

endmodule

// ===== tb/testbench.sv =====
// Testbench for the pressure and temperature compensation block: scoreboard, drivers and checks.
module testbench;
    import ptc_pkg::*;

    localparam longint CycleLimit = 2000000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_idx;
    logic [CfgDataW-1:0] i_cfg_data;
    logic                i_in_valid;
    logic                o_in_ready;
    t_in_item            i_in_data;
    logic                o_out_valid;
    logic                i_out_ready;
    t_out_item           o_out_data;

    pressure_temperature_compensation dut (.*);

    // Compensation predictor with its own copy of the calibration and the fine temperature.
    class comp_scoreboard;
        logic [47:0] temp_coef;
        logic [63:0] pres_low;
        logic [63:0] pres_high;
        logic [15:0] pres_nine;
        logic signed [31:0] fine_temp;
        t_out_item   pending[$];
        int          mismatches;
        int          checked;
        int          n_temp;
        int          n_pres;
        int          n_zero;

        function new();
            temp_coef = '0;
            pres_low  = '0;
            pres_high = '0;
            pres_nine = '0;
            fine_temp = '0;
            mismatches = 0;
            checked = 0;
            n_temp = 0;
            n_pres = 0;
            n_zero = 0;
        endfunction

        function void write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] val);
            case (idx)
                REG_TEMP_COEF: temp_coef = val[47:0];
                REG_PRES_LOW:  pres_low  = val;
                REG_PRES_HIGH: pres_high = val;
                REG_PRES_NINE: pres_nine = val[15:0];
                default: ;
            endcase
        endfunction

        // Signed 16-bit slice of a coefficient word.
        function longint slice(logic [63:0] w, int k);
            logic signed [15:0] s;
            s = w[16*k +: 16];
            return longint'(s);
        endfunction

        // Signed divide toward zero with wrap of the most negative dividend over -1.
        function longint div64(longint n, longint d);
            logic [63:0] an;
            logic [63:0] ad;
            logic [63:0] q;
            an = (n < 0) ? -n : n;
            ad = (d < 0) ? -d : d;
            q  = an / ad;
            return ((n < 0) != (d < 0)) ? longint'(-q) : longint'(q);
        endfunction

        function void note_input(t_in_item it);
            t_out_item e;
            longint t1, t2, t3, dd, a, b, p, tf;
            longint p1, p2, p3, p4, p5, p6, p7, p8, p9;
            longint raw;
            e = '0;
            e.kind = it.action;
            raw = longint'({44'd0, it.raw_sample});
            if (it.action == 1'b0) begin
                t1 = longint'({48'd0, temp_coef[15:0]});
                t2 = slice({16'd0, temp_coef}, 1);
                t3 = slice({16'd0, temp_coef}, 2);
                dd = (raw >>> 4) - t1;
                a = (((raw >>> 3) - (t1 <<< 1)) * t2) >>> 11;
                b = (((dd * dd) >>> 12) * t3) >>> 14;
                fine_temp = 32'(a + b);
                tf = longint'(fine_temp);
                p = (tf * 5 + 128) >>> 8;
                e.temperature = p[31:0];
                n_temp++;
            end else begin
                p1 = longint'({48'd0, pres_low[15:0]});
                p2 = slice(pres_low, 1);
                p3 = slice(pres_low, 2);
                p4 = slice(pres_low, 3);
                p5 = slice(pres_high, 0);
                p6 = slice(pres_high, 1);
                p7 = slice(pres_high, 2);
                p8 = slice(pres_high, 3);
                p9 = slice({48'd0, pres_nine}, 0);
                tf = longint'(fine_temp);
                a = tf - 128000;
                b = a * a * p6;
                b = b + ((a * p5) <<< 17);
                b = b + (p4 <<< 35);
                a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
                a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
                if (a == 0) begin
                    e.divide_by_zero = 1'b1;
                    n_zero++;
                end else begin
                    p = 1048576 - raw;
                    p = div64(((p <<< 31) - b) * 3125, a);
                    a = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
                    b = (p8 * p) >>> 19;
                    p = ((p + a + b) >>> 8) + (p7 <<< 4);
                    e.pressure = p[31:0];
                end
                n_pres++;
            end
            pending.push_back(e);
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            e = pending.pop_front();
            if (got !== e) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: kind %0d/%0d temp %0d/%0d pres %h/%h dz %0d/%0d",
                             e.kind, got.kind, e.temperature, got.temperature,
                             e.pressure, got.pressure, e.divide_by_zero, got.divide_by_zero);
            end
        endfunction
    endclass

    comp_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    longint cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Cycle limit guard.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CycleLimit) begin
                $display("timeout after %0d cycles", cycles);
                $display("** pressure_temperature_compensation: FAILED **");
                $finish;
            end
        end
    end

    // Result side: random stalls and checking of every transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_out_data);
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // One register write, after which the task returns with the write enable low.
    task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [63:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        sb.write_reg(idx, val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offer one item and hold it until the transfer.
    task automatic send_item(logic act, logic [19:0] raw);
        t_in_item it;
        it.action = act;
        it.raw_sample = raw;
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(it);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // Calibration set: plausible sensor values, all ones, extreme 16-bit values, or fully random words.
    task automatic load_cal(int style);
        case (style)
            0: begin
                write_cfg(REG_TEMP_COEF, {16'hFC18, 16'd26435, 16'd27504});
                write_cfg(REG_PRES_LOW, {16'd2855, 16'hD8D3, 16'hD8BA, 16'd36477});
                write_cfg(REG_PRES_HIGH, {16'hFFF9, 16'd15500, 16'hFFF9, 16'd140});
                write_cfg(REG_PRES_NINE, 64'd6000);
            end
            1: begin
                write_cfg(REG_TEMP_COEF, 64'hFFFF_FFFF_FFFF);
                write_cfg(REG_PRES_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
                write_cfg(REG_PRES_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
                write_cfg(REG_PRES_NINE, 64'hFFFF);
            end
            2: begin
                write_cfg(REG_TEMP_COEF, {16'h8000, 16'h7FFF, 16'h0000});
                write_cfg(REG_PRES_LOW, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h0001});
                write_cfg(REG_PRES_HIGH, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
                write_cfg(REG_PRES_NINE, 64'h8000);
            end
            default: begin
                write_cfg(REG_TEMP_COEF, {$urandom, $urandom});
                write_cfg(REG_PRES_LOW, {$urandom, $urandom});
                write_cfg(REG_PRES_HIGH, {$urandom, $urandom});
                write_cfg(REG_PRES_NINE, {$urandom, $urandom});
            end
        endcase
    endtask

    initial begin
        int ph;
        sb = new();
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: pressure before any temperature, with zero calibration (zero divisor).
        send_item(1'b1, 20'd0);
        send_item(1'b0, 20'hFFFFF);
        send_item(1'b1, 20'hFFFFF);
        drain();
        load_cal(0);
        send_item(1'b1, 20'd415148);
        send_item(1'b0, 20'd519888);
        send_item(1'b1, 20'd415148);
        send_item(1'b0, 20'd0);
        send_item(1'b1, 20'd0);
        send_item(1'b0, 20'hFFFFF);
        send_item(1'b1, 20'hFFFFF);
        drain();
        load_cal(1);
        send_item(1'b0, 20'hFFFFF);
        send_item(1'b1, 20'h55555);
        send_item(1'b0, 20'h00000);
        send_item(1'b1, 20'hAAAAA);
        drain();
        load_cal(2);
        send_item(1'b0, 20'h80000);
        send_item(1'b1, 20'h7FFFF);
        send_item(1'b0, 20'hFFFFF);
        send_item(1'b1, 20'd1);
        drain();
        // Zero P1 forces a zero divisor with a nonzero fine temperature.
        write_cfg(REG_PRES_LOW, 64'h1234_5678_9ABC_0000);
        send_item(1'b0, 20'd300000);
        send_item(1'b1, 20'd300000);
        drain();

        // Random phases across idling patterns and calibration sets.
        for (ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            load_cal((ph < 4) ? ((ph == 1) ? 0 : 3) : ((ph == 5) ? 1 : 3));
            repeat (100) begin
                if ($urandom_range(3) == 0)
                    send_item(1'b0, 20'($urandom));
                else
                    send_item(1'($urandom), 20'($urandom));
            end
            drain();
        end

        $display("covered %0d temperature and %0d pressure items, %0d zero divisors,",
                 sb.n_temp, sb.n_pres, sb.n_zero);
        $display("over several calibration sets and idling patterns; %0d results checked",
                 sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("** pressure_temperature_compensation: PASSED **");
        else
            $display("** pressure_temperature_compensation: FAILED **");
        $finish;
    end
endmodule
